/* hw/rtl/ted_pkg.sv */
`default_nettype none
package ted_pkg;

   localparam logic [3:0] SAMPLE_BYTES = 4'd12;
   localparam logic [2:0] FREEZE_COUNT = 3'd5;

   localparam logic [7:0] BYTE_EF = 8'hEF;
   localparam logic [7:0] BYTE_BB = 8'hBB;
   localparam logic [7:0] BYTE_BF = 8'hBF;
   localparam logic [7:0] BYTE_FE = 8'hFE;
   localparam logic [7:0] BYTE_FF = 8'hFF;
   localparam logic [7:0] BYTE_NL = 8'h0A;
   localparam logic [7:0] BYTE_80 = 8'h80;
   localparam logic [7:0] SIMP_LO = 8'hC6;
   localparam logic [7:0] SIMP_HI = 8'hD7;
   localparam logic [7:0] TRAD_LO = 8'hA4;
   localparam logic [7:0] TRAD_MID = 8'hA9;
   localparam logic [7:0] TRAD_HI = 8'hAF;
   localparam logic [7:0] TRAIL_LO = 8'hA1;
   localparam logic [7:0] TRAIL_HI = 8'hFE;

   typedef enum logic [2:0] {
      ENC_UTF8      = 3'd0,
      ENC_UTF16_BE  = 3'd1,
      ENC_UTF16_LE  = 3'd2,
      ENC_GBK       = 3'd3,
      ENC_BIG5      = 3'd4
   } encoding_type;

   typedef enum logic [1:0] {
      NL_BEFORE  = 2'd0,
      NL_SKIP    = 2'd1,
      NL_COLLECT = 2'd2,
      NL_DONE    = 2'd3
   } newline_type;

   typedef enum logic [1:0] {
      B5_UNDECIDED = 2'd0,
      B5_GBK       = 2'd1,
      B5_BIG5      = 2'd2
   } big5_type;

   typedef struct packed {
      logic [2:0] pending;
      logic       fail;
   } utf8_type;

   typedef struct packed {
      logic [1:0]  byte_position;
      logic [2:0]  bom_candidates;
      logic        first_zero_seen;
      logic        first_zero_odd;
      logic        parity_bit;
      logic [3:0]  high_count;
      utf8_type    high_utf8;
      logic [7:0]  first_high_value;
      newline_type newline_phase;
      logic [3:0]  tail_count;
      utf8_type    tail_utf8;
      logic [2:0]  simplified_count;
      logic [2:0]  traditional_count;
      big5_type    big5_decided;
      logic [8:0]  previous_byte;
   } detect_type;

   function automatic detect_type detect_reset();
      detect_type d;
      d                   = '0;
      d.bom_candidates    = 3'b111;
      d.newline_phase     = NL_BEFORE;
      d.big5_decided      = B5_UNDECIDED;
      return d;
   endfunction

   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic utf8_type utf8_feed(input utf8_type st, input logic [7:0] b);
      utf8_type   r;
      logic [3:0] ones;
      r    = st;
      ones = lead_ones(b);
      if (!st.fail) begin
         if (st.pending == 3'd0) begin
            if (b[7]) begin
               if (ones == 4'd1) begin
                  r.fail = 1'b1;
               end else begin
                  r.pending = 3'(ones - 4'd1);
               end
            end
         end else begin
            if (b[7:6] != 2'b10) begin
               r.fail = 1'b1;
            end else begin
               r.pending = st.pending - 3'd1;
            end
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/text_encoding_detector.sv */
// text encoding detector
// input channel (req_): one byte of a text buffer per word, req_last_byte
// marks the final byte of the buffer. every byte updates small trackers:
// byte order mark, first zero byte, utf-8 check on the first high bytes,
// utf-8 check on the bytes after the first newline, and a big5/gbk count
// result channel (rsp_): one word per buffer, rsp_encoding_code
// (0 utf-8, 1 utf-16 be, 2 utf-16 le, 3 gbk, 4 big5), no word for other bytes
// throughput: one byte per cycle, set by the single update stage between the
// input register and the result register, while no last byte is held back by
// a pending result that the receiver has not taken; the last byte's code is
// registered in the result register after it passes the update stage
// after the last byte the trackers clear so the next byte starts a new buffer
// reset clears the trackers and empties both pipeline registers
// when the receiver stalls, the result is held; further non-last bytes keep
// flowing, and a second last byte waits in the input register until the
// pending result is taken
`default_nettype none
module text_encoding_detector (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_value,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_encoding_code
);
   import ted_pkg::*;

   logic         in_valid_ff;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         out_valid_ff;
   logic         out_valid_in;
   encoding_type out_code_ff;
   encoding_type out_code_in;
   detect_type   det_ff;
   detect_type   det_in;
   detect_type   upd;
   logic         advance;
   logic [7:0]   b;
   logic [7:0]   hi;

   assign advance   = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_encoding_code = out_code_ff;
   assign b  = in_byte_ff;
   assign hi = det_ff.previous_byte[7:0];

   always_comb begin
      upd = det_ff;

      // byte order mark
      unique case (det_ff.byte_position)
         2'd0: begin
            if (b != BYTE_EF) upd.bom_candidates[0] = 1'b0;
            if (b != BYTE_FE) upd.bom_candidates[1] = 1'b0;
            if (b != BYTE_FF) upd.bom_candidates[2] = 1'b0;
         end
         2'd1: begin
            if (b != BYTE_BB) upd.bom_candidates[0] = 1'b0;
            if (b != BYTE_FF) upd.bom_candidates[1] = 1'b0;
            if (b != BYTE_FE) upd.bom_candidates[2] = 1'b0;
         end
         2'd2: begin
            if (b != BYTE_BF) upd.bom_candidates[0] = 1'b0;
         end
         default: begin
         end
      endcase
      if (det_ff.byte_position != 2'd3) begin
         upd.byte_position = det_ff.byte_position + 2'd1;
      end

      // first zero byte
      if (b == 8'd0 && !det_ff.first_zero_seen) begin
         upd.first_zero_seen = 1'b1;
         upd.first_zero_odd  = det_ff.parity_bit;
      end
      upd.parity_bit = !det_ff.parity_bit;

      // utf-8 on high bytes
      if (b[7] && det_ff.high_count < SAMPLE_BYTES) begin
         if (det_ff.high_count == 4'd0) begin
            upd.first_high_value = b;
         end
         upd.high_count = det_ff.high_count + 4'd1;
         upd.high_utf8  = utf8_feed(det_ff.high_utf8, b);
      end

      // utf-8 after first newline
      unique case (det_ff.newline_phase)
         NL_BEFORE: begin
            if (b == BYTE_NL) upd.newline_phase = NL_SKIP;
         end
         NL_SKIP: begin
            if (b > BYTE_80) begin
               upd.newline_phase = NL_COLLECT;
               upd.tail_count    = 4'd1;
               upd.tail_utf8     = utf8_feed(det_ff.tail_utf8, b);
            end
         end
         NL_COLLECT: begin
            if (det_ff.tail_count < SAMPLE_BYTES) begin
               upd.tail_count = det_ff.tail_count + 4'd1;
               upd.tail_utf8  = utf8_feed(det_ff.tail_utf8, b);
            end else begin
               upd.newline_phase = NL_DONE;
            end
         end
         default: begin
         end
      endcase

      // big5 versus gbk lead byte count
      if (det_ff.previous_byte[8] && det_ff.big5_decided == B5_UNDECIDED) begin
         if (hi[7]) begin
            if (hi >= SIMP_LO && hi <= SIMP_HI) begin
               upd.simplified_count = det_ff.simplified_count + 3'd1;
            end else if (hi >= TRAD_LO && hi <= TRAD_HI) begin
               if (hi <= TRAD_MID) begin
                  upd.traditional_count = det_ff.traditional_count + 3'd1;
               end else if (b >= TRAIL_LO && b <= TRAIL_HI) begin
                  upd.big5_decided = B5_BIG5;
               end else begin
                  upd.traditional_count = det_ff.traditional_count + 3'd1;
               end
            end
            upd.previous_byte = '0;
         end else begin
            upd.previous_byte = {1'b1, b};
         end
         if (upd.big5_decided == B5_UNDECIDED &&
             (upd.simplified_count >= FREEZE_COUNT ||
              upd.traditional_count >= FREEZE_COUNT)) begin
            upd.big5_decided = (upd.simplified_count >= upd.traditional_count) ?
                               B5_GBK : B5_BIG5;
         end
      end else if (det_ff.big5_decided == B5_UNDECIDED) begin
         upd.previous_byte = {1'b1, b};
      end
   end

   always_comb begin
      priority if (upd.bom_candidates[0] && upd.byte_position == 2'd3) begin
         out_code_in = ENC_UTF8;
      end else if (upd.bom_candidates[1] && upd.byte_position >= 2'd2) begin
         out_code_in = ENC_UTF16_BE;
      end else if (upd.bom_candidates[2] && upd.byte_position >= 2'd2) begin
         out_code_in = ENC_UTF16_LE;
      end else if (upd.first_zero_seen) begin
         out_code_in = upd.first_zero_odd ? ENC_UTF16_LE : ENC_UTF16_BE;
      end else if (upd.high_count != 4'd0 && !upd.high_utf8.fail &&
                   upd.high_utf8.pending == 3'd0) begin
         out_code_in = ENC_UTF8;
      end else if (upd.newline_phase == NL_DONE && upd.first_high_value <= BYTE_80 &&
                   !upd.tail_utf8.fail && upd.tail_utf8.pending == 3'd0) begin
         out_code_in = ENC_UTF8;
      end else if (upd.big5_decided == B5_BIG5) begin
         out_code_in = ENC_BIG5;
      end else if (upd.big5_decided == B5_GBK) begin
         out_code_in = ENC_GBK;
      end else begin
         out_code_in = (upd.simplified_count >= upd.traditional_count) ?
                       ENC_GBK : ENC_BIG5;
      end
   end

   always_comb begin
      det_in = in_last_ff ? detect_reset() : upd;
      if (advance && in_last_ff) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         det_ff       <= detect_reset();
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            det_ff <= det_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_byte_value;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_code_ff <= out_code_in;
      end
   end

endmodule
`default_nettype wire
